[rtl/lcw_stream_decompressor_top_defines.svh]
// assertion macros shared by the lcw decompressor modules
`ifndef LCW_STREAM_DECOMPRESSOR_TOP_DEFINES_SVH
`define LCW_STREAM_DECOMPRESSOR_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LCW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lcw check failed");

// next-cycle implication, checked out of reset
`define LCW_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lcw check failed");

`endif

[rtl/lcw_pkg.sv]
// types and constants of the lcw stream decompressor
package lcw_pkg;

    localparam int OUT_BYTES = 65536;
    localparam int AW        = $clog2(OUT_BYTES);
    localparam int IQ_DEPTH  = 2;
    localparam int OQ_DEPTH  = 4;

    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_PULL    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [2:0] K_DATA    = 3'd0;
    localparam logic [2:0] K_DONE    = 3'd1;
    localparam logic [2:0] K_TRUNC   = 3'd2;
    localparam logic [2:0] K_CAP     = 3'd3;
    localparam logic [2:0] K_REFUSED = 3'd4;

    localparam logic [2:0] PH_CMD   = 3'd0;
    localparam logic [2:0] PH_SHORT = 3'd1;
    localparam logic [2:0] PH_LIT   = 3'd2;
    localparam logic [2:0] PH_P1    = 3'd3;
    localparam logic [2:0] PH_P2    = 3'd4;
    localparam logic [2:0] PH_P3    = 3'd5;
    localparam logic [2:0] PH_P4    = 3'd6;
    localparam logic [2:0] PH_RUN   = 3'd7;

    localparam logic [7:0] CMD_END  = 8'h80;
    localparam logic [7:0] CMD_FILL = 8'hFE;
    localparam logic [7:0] CMD_LONG = 8'hFF;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [2:0]  out_kind;
        logic [7:0]  out_byte;
        logic [16:0] total_length;
    } t_out;

    // classified word handed from front to back
    typedef struct packed {
        logic       is_byte;
        logic       is_pull;
        logic       is_restart;
        logic [7:0] data;
        logic       last;
    } t_cmd;

endpackage

[rtl/lcw_front.sv]
// input queue that accepts and classifies words
module lcw_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  lcw_pkg::t_in  i_in,
    input  logic          i_take,
    output logic          o_valid,
    output lcw_pkg::t_cmd o_cmd
);
    lcw_pkg::t_cmd r_q [lcw_pkg::IQ_DEPTH];
    logic [$clog2(lcw_pkg::IQ_DEPTH)-1:0] r_wr, r_rd;
    logic [$clog2(lcw_pkg::IQ_DEPTH+1)-1:0] r_cnt;
    lcw_pkg::t_cmd cls;
    logic do_push, do_pop;

    always_comb begin
        cls.is_byte    = (i_in.opcode == lcw_pkg::OP_BYTE);
        cls.is_pull    = (i_in.opcode == lcw_pkg::OP_PULL);
        cls.is_restart = (i_in.opcode == lcw_pkg::OP_RESTART);
        cls.data       = i_in.in_byte;
        cls.last       = i_in.in_last;
    end

    assign full    = (r_cnt == ($clog2(lcw_pkg::IQ_DEPTH+1))'(lcw_pkg::IQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_q[r_rd];
    assign do_push = push && !full;
    assign do_pop  = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            if (do_push && !do_pop) r_cnt <= r_cnt + 1'b1;
            else if (!do_push && do_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_q[r_wr] <= cls;
    end
endmodule

[rtl/lcw_back.sv]
// parser, run engine and history store
`include "lcw_stream_decompressor_top_defines.svh"
module lcw_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  lcw_pkg::t_cmd i_cmd,
    input  logic          i_room,
    output logic          o_take,
    input  logic          i_cfg_valid,
    input  logic [16:0]   i_cfg_data,
    output logic          o_push,
    output lcw_pkg::t_out o_res
);
    localparam int AW = lcw_pkg::AW;

    logic [7:0] r_mem [lcw_pkg::OUT_BYTES];

    logic [16:0] r_cap;
    logic [16:0] r_wp, n_wp;
    logic [2:0]  r_ph, n_ph;
    logic [7:0]  r_cmd, n_cmd;
    logic [15:0] r_rem, n_rem;
    logic [17:0] r_src, n_src;
    logic [7:0]  r_fill, n_fill;
    logic        r_isfill, n_isfill;
    logic        r_inv, n_inv;
    logic        r_end, n_end;
    logic        r_stop, n_stop;

    // second stage: result being formed, store write pending
    logic          r_b_valid, n_b_valid;
    logic          r_b_we, n_b_we;
    logic          r_b_mem, n_b_mem;
    logic          r_b_fwd, n_b_fwd;
    logic [2:0]    r_b_kind, n_b_kind;
    logic [7:0]    r_b_imm, n_b_imm;
    logic [16:0]   r_b_len;
    logic [AW-1:0] r_b_waddr, n_b_waddr;
    logic [7:0]    r_rdata, r_lastv, b_val;

    logic        go;
    logic [16:0] lim;
    logic        at_cap;
    logic [11:0] off;
    logic [15:0] rem_dec;
    logic [17:0] src_inc;

    assign go      = i_valid && i_room;
    assign o_take  = go;
    assign lim     = (r_cap < 17'(lcw_pkg::OUT_BYTES)) ? r_cap : 17'(lcw_pkg::OUT_BYTES);
    assign at_cap  = (r_wp >= lim);
    assign off     = {r_cmd[3:0], i_cmd.data};
    assign rem_dec = r_rem - 16'd1;
    assign src_inc = r_src + 18'd1;

    always_comb begin
        n_wp = r_wp; n_ph = r_ph; n_cmd = r_cmd; n_rem = r_rem; n_src = r_src;
        n_fill = r_fill; n_isfill = r_isfill; n_inv = r_inv; n_end = r_end;
        n_stop = r_stop;
        n_b_valid = 1'b0; n_b_we = 1'b0; n_b_mem = 1'b0; n_b_fwd = 1'b0;
        n_b_kind = lcw_pkg::K_DATA; n_b_imm = 8'd0; n_b_waddr = r_wp[AW-1:0];
        if (go) begin
            if (i_cmd.is_restart) begin
                n_wp = '0; n_ph = lcw_pkg::PH_CMD; n_cmd = '0; n_rem = '0; n_src = '0;
                n_fill = '0; n_isfill = 1'b0; n_inv = 1'b0; n_end = 1'b0; n_stop = 1'b0;
            end else if (r_stop) begin
                n_stop = 1'b1;
            end else if (i_cmd.is_pull) begin
                if (r_ph != lcw_pkg::PH_RUN) begin
                    if (r_end) begin
                        n_b_valid = 1'b1;
                        n_b_kind  = lcw_pkg::K_DONE;
                    end
                end else if (at_cap) begin
                    n_stop = 1'b1; n_b_valid = 1'b1; n_b_kind = lcw_pkg::K_CAP;
                end else begin
                    if (r_isfill) begin
                        n_b_imm = r_fill;
                    end else if (!r_inv && (r_src < {1'b0, r_wp})) begin
                        n_b_mem = 1'b1;
                        // source is the byte still being written by the stage ahead
                        n_b_fwd = r_b_valid && r_b_we && (r_src[AW-1:0] == r_b_waddr);
                    end
                    n_src = src_inc;
                    if (src_inc == '0) n_inv = 1'b0;
                    n_b_valid = 1'b1; n_b_we = 1'b1;
                    n_wp  = r_wp + 17'd1;
                    n_rem = rem_dec;
                    if (rem_dec == '0) n_ph = lcw_pkg::PH_CMD;
                end
            end else if (i_cmd.is_byte) begin
                if (r_ph == lcw_pkg::PH_RUN) begin
                    n_b_valid = 1'b1; n_b_kind = lcw_pkg::K_REFUSED;
                end else if (r_end) begin
                    n_end = 1'b1;
                end else if (r_ph == lcw_pkg::PH_LIT) begin
                    if (at_cap) begin
                        n_stop = 1'b1; n_b_valid = 1'b1; n_b_kind = lcw_pkg::K_CAP;
                    end else begin
                        n_rem = rem_dec;
                        if (rem_dec == '0) n_ph = lcw_pkg::PH_CMD;
                        n_b_valid = 1'b1;
                        if (i_cmd.last && (rem_dec != '0)) begin
                            n_stop = 1'b1; n_b_kind = lcw_pkg::K_TRUNC;
                        end else begin
                            n_b_we  = 1'b1;
                            n_b_imm = i_cmd.data;
                            n_wp    = r_wp + 17'd1;
                            if (i_cmd.last) n_end = 1'b1;
                        end
                    end
                end else begin
                    case (r_ph)
                        lcw_pkg::PH_CMD: begin
                            n_cmd = i_cmd.data;
                            if (!i_cmd.data[7]) begin
                                n_ph = lcw_pkg::PH_SHORT;
                            end else if (i_cmd.data == lcw_pkg::CMD_END) begin
                                n_end = 1'b1;
                            end else if (!i_cmd.data[6]) begin
                                n_rem = {10'd0, i_cmd.data[5:0]};
                                n_ph  = (i_cmd.data[5:0] != '0) ? lcw_pkg::PH_LIT
                                                                : lcw_pkg::PH_CMD;
                            end else begin
                                n_rem = '0; n_src = '0; n_ph = lcw_pkg::PH_P1;
                            end
                        end
                        lcw_pkg::PH_SHORT: begin
                            n_isfill = 1'b0;
                            n_rem    = 16'({1'b0, r_cmd[6:4]}) + 16'd3;
                            n_src    = {1'b0, r_wp} - {6'd0, off};
                            n_inv    = ({5'd0, off} > r_wp);
                            n_ph     = lcw_pkg::PH_RUN;
                        end
                        lcw_pkg::PH_P1: begin
                            if (r_cmd == lcw_pkg::CMD_FILL || r_cmd == lcw_pkg::CMD_LONG)
                                n_rem = {8'd0, i_cmd.data};
                            else
                                n_src = {10'd0, i_cmd.data};
                            n_ph = lcw_pkg::PH_P2;
                        end
                        lcw_pkg::PH_P2: begin
                            if (r_cmd == lcw_pkg::CMD_FILL || r_cmd == lcw_pkg::CMD_LONG) begin
                                n_rem = {i_cmd.data, r_rem[7:0]};
                                n_ph  = lcw_pkg::PH_P3;
                            end else begin
                                n_isfill = 1'b0;
                                n_rem    = {10'd0, r_cmd[5:0]} + 16'd3;
                                n_src    = {2'd0, i_cmd.data, r_src[7:0]};
                                n_inv    = 1'b0;
                                n_ph     = lcw_pkg::PH_RUN;
                            end
                        end
                        lcw_pkg::PH_P3: begin
                            if (r_cmd == lcw_pkg::CMD_FILL) begin
                                n_fill   = i_cmd.data;
                                n_isfill = 1'b1;
                                n_src    = '0;
                                n_inv    = 1'b0;
                                n_ph     = (r_rem != '0) ? lcw_pkg::PH_RUN : lcw_pkg::PH_CMD;
                            end else begin
                                n_src = {10'd0, i_cmd.data};
                                n_ph  = lcw_pkg::PH_P4;
                            end
                        end
                        lcw_pkg::PH_P4: begin
                            n_isfill = 1'b0;
                            n_src    = {2'd0, i_cmd.data, r_src[7:0]};
                            n_inv    = 1'b0;
                            n_ph     = (r_rem != '0) ? lcw_pkg::PH_RUN : lcw_pkg::PH_CMD;
                        end
                        default: n_ph = lcw_pkg::PH_CMD;
                    endcase
                    if (i_cmd.last && !n_end) begin
                        if (n_ph != lcw_pkg::PH_CMD && n_ph != lcw_pkg::PH_RUN) begin
                            n_stop = 1'b1; n_b_valid = 1'b1; n_b_kind = lcw_pkg::K_TRUNC;
                        end else begin
                            n_end = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 17'(lcw_pkg::OUT_BYTES);
            r_wp <= '0; r_ph <= lcw_pkg::PH_CMD; r_cmd <= '0; r_rem <= '0; r_src <= '0;
            r_fill <= '0; r_isfill <= 1'b0; r_inv <= 1'b0; r_end <= 1'b0; r_stop <= 1'b0;
            r_b_valid <= 1'b0; r_b_we <= 1'b0;
        end else begin
            if (i_cfg_valid) r_cap <= i_cfg_data;
            r_wp <= n_wp; r_ph <= n_ph; r_cmd <= n_cmd; r_rem <= n_rem; r_src <= n_src;
            r_fill <= n_fill; r_isfill <= n_isfill; r_inv <= n_inv; r_end <= n_end;
            r_stop <= n_stop;
            r_b_valid <= n_b_valid; r_b_we <= n_b_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_mem <= n_b_mem; r_b_fwd <= n_b_fwd; r_b_kind <= n_b_kind;
        r_b_imm <= n_b_imm; r_b_waddr <= n_b_waddr; r_b_len <= n_wp;
    end

    assign b_val = r_b_mem ? (r_b_fwd ? r_lastv : r_rdata) : r_b_imm;

    // history store: read for the next word, write of the word in the second stage
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[r_src[AW-1:0]];
        if (r_b_we) begin
            r_mem[r_b_waddr] <= b_val;
            r_lastv <= b_val;
        end
    end

    assign o_push = r_b_valid;
    always_comb begin
        o_res.out_kind     = r_b_kind;
        o_res.out_byte     = (r_b_kind == lcw_pkg::K_DATA) ? b_val : 8'd0;
        o_res.total_length = r_b_len;
    end

    `LCW_ASSERT_IMP(a_we_emits, r_b_we, r_b_valid && (r_b_kind == lcw_pkg::K_DATA))
    `LCW_ASSERT_NXT(a_stop_quiet, go && r_stop && !i_cmd.is_restart, !r_b_valid)
    `LCW_ASSERT_IMP(a_wp_bound, 1'b1, r_wp <= 17'(lcw_pkg::OUT_BYTES))
endmodule

[rtl/lcw_oq.sv]
// result queue toward the consumer
`include "lcw_stream_decompressor_top_defines.svh"
module lcw_oq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lcw_pkg::t_out i_res,
    output logic          o_room,
    output logic          empty,
    input  logic          pop,
    output lcw_pkg::t_out o_out
);
    localparam int CW = $clog2(lcw_pkg::OQ_DEPTH + 1);

    lcw_pkg::t_out r_q [lcw_pkg::OQ_DEPTH];
    logic [$clog2(lcw_pkg::OQ_DEPTH)-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic do_pop;

    // two free slots: one for the word in the back's second stage, one for a new issue
    assign o_room = (r_cnt <= CW'(lcw_pkg::OQ_DEPTH - 2));
    assign empty  = (r_cnt == '0);
    assign o_out  = r_q[r_rd];
    assign do_pop = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (do_pop) r_rd <= r_rd + 1'b1;
            if (i_push && !do_pop) r_cnt <= r_cnt + 1'b1;
            else if (!i_push && do_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wr] <= i_res;
    end

    `LCW_ASSERT_IMP(a_no_overflow, i_push, r_cnt != CW'(lcw_pkg::OQ_DEPTH))
endmodule

[rtl/lcw_stream_decompressor_top.sv]
// top level of the lcw stream decompressor
// channels: input words enter by push/full (opcode, byte, last mark);
// results leave by empty/pop, the oldest result on o_out while empty is low;
// the output byte limit is written on i_cfg_valid/o_cfg_ready (always ready);
// the user must write it only while the block is idle; the block does not enforce it.
// a word enters a two-entry input queue, the back end takes one word per
// cycle while the result queue has room, parses or runs it and reads the
// history store; results pass the second stage into the result queue.
// throughput, with room in the result queue, is one word per cycle, set by the
// single read and single write port of the 64 KiB history store; overlapping
// copies are forwarded. when the receiver stalls, the four-entry result queue
// fills, the back end stops taking words and the input queue raises full.
// after reset the queues are empty, the stream state is cleared and the limit
// is 65536; the history store is not cleared, reads are gated by the
// written length instead.
module lcw_stream_decompressor_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  lcw_pkg::t_in  i_in,
    output logic          empty,
    input  logic          pop,
    output lcw_pkg::t_out o_out,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [16:0]   i_cfg_data
);
    lcw_pkg::t_cmd cmd;
    lcw_pkg::t_out res;
    logic f_valid, take, room, res_push;

    assign o_cfg_ready = 1'b1;

    lcw_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_in(i_in),
        .i_take(take), .o_valid(f_valid), .o_cmd(cmd)
    );

    lcw_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(f_valid), .i_cmd(cmd),
        .i_room(room), .o_take(take), .i_cfg_valid(i_cfg_valid),
        .i_cfg_data(i_cfg_data), .o_push(res_push), .o_res(res)
    );

    lcw_oq u_oq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(res_push), .i_res(res),
        .o_room(room), .empty(empty), .pop(pop), .o_out(o_out)
    );
endmodule
